>>> hw/rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
`default_nettype none
package skt_pkg;

  localparam int KeyWidth = 32;
  localparam int CmdWidth = 2;
  localparam int StatusWidth = 3;

  typedef logic [CmdWidth-1:0] cmd_t;
  typedef logic [StatusWidth-1:0] status_t;
  typedef logic signed [KeyWidth-1:0] key_t;

  localparam cmd_t CMD_UPSERT = 2'd0;
  localparam cmd_t CMD_LOOKUP = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;
  localparam cmd_t CMD_SPARE = 2'd3;

  localparam status_t ST_INSERTED = 3'd0;
  localparam status_t ST_UPDATED = 3'd1;
  localparam status_t ST_FOUND = 3'd2;
  localparam status_t ST_NOT_FOUND = 3'd3;
  localparam status_t ST_REMOVED = 3'd4;
  localparam status_t ST_FULL = 3'd5;

  // Commands from the controller to the cell array.
  typedef struct packed {
    logic capture;
    logic execute;
  } ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/skt_req_if.sv
// Request channel: command, key and payload with valid/ready.
`default_nettype none
interface skt_req_if #(
  parameter int PAYLOAD_WIDTH = 32
);
  import skt_pkg::*;

  logic valid;
  logic ready;
  cmd_t cmd;
  key_t key;
  logic [PAYLOAD_WIDTH-1:0] payload;

  modport source (output valid, output cmd, output key, output payload, input ready);
  modport sink (input valid, input cmd, input key, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/skt_rsp_if.sv
// Response channel: status, payload, position and entry count with valid/ready.
`default_nettype none
interface skt_rsp_if #(
  parameter int PAYLOAD_WIDTH = 32,
  parameter int COUNT_WIDTH = 7
);
  import skt_pkg::*;

  logic valid;
  logic ready;
  status_t status;
  logic [PAYLOAD_WIDTH-1:0] payload_out;
  logic [COUNT_WIDTH-1:0] position;
  logic [COUNT_WIDTH-1:0] entry_count;

  modport source (output valid, output status, output payload_out, output position,
                  output entry_count, input ready);
  modport sink (input valid, input status, input payload_out, input position,
                input entry_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/skt_ctrl.sv
// Controller: accepts an item, runs the execute step and holds the result valid.
`default_nettype none
module skt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output skt_pkg::ctl_t    ctl
);
  import skt_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;

  always_comb begin
    // take no item while reset is held
    req_ready = (state == S_IDLE) && !rst;
    ctl.capture = req_valid && req_ready;
    // execute only when the result register is free or being drained
    ctl.execute = (state == S_EXEC) && (!rsp_valid || rsp_ready);
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (ctl.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (ctl.execute) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (ctl.execute) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/skt_cells.sv
// Datapath: sorted cell array with per-cell compare, shift and the result register.
`default_nettype none
module skt_cells #(
  parameter int TABLE_DEPTH = 64,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire skt_pkg::ctl_t            ctl,
  input  wire skt_pkg::cmd_t            in_cmd,
  input  wire skt_pkg::key_t            in_key,
  input  wire logic [PAYLOAD_WIDTH-1:0] in_payload,
  output skt_pkg::status_t              status,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out,
  output logic [COUNT_WIDTH-1:0]        position,
  output logic [COUNT_WIDTH-1:0]        entry_count
);
  import skt_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(TABLE_DEPTH);

  key_t                     keys [TABLE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pays [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]   count;
  logic [COUNT_WIDTH-1:0]   count_next;

  cmd_t                     cmd_q;
  key_t                     key_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [TABLE_DEPTH-1:0]   lt;
  logic [TABLE_DEPTH-1:0]   eq;

  logic [TABLE_DEPTH-1:0]   lt_prev;
  logic [TABLE_DEPTH:0]     edge_hot;
  logic                     hit;
  logic                     full;
  logic                     do_ins;
  logic                     do_upd;
  logic                     do_rem;
  logic [COUNT_WIDTH-1:0]   pos_enc;
  logic [PAYLOAD_WIDTH-1:0] hit_pay;
  status_t                  status_next;

  // Compare every held cell against the incoming key as the item is taken.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
      pay_q <= in_payload;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        lt[i] <= (COUNT_WIDTH'(i) < count) && (keys[i] < in_key);
        eq[i] <= (COUNT_WIDTH'(i) < count) && (keys[i] == in_key);
      end
    end
  end

  always_comb begin
    lt_prev = {lt[TABLE_DEPTH-2:0], 1'b1};
    // lt is a thermometer; its edge marks the lower bound
    edge_hot = {lt[TABLE_DEPTH-1], lt_prev & ~lt};
    pos_enc = '0;
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      if (edge_hot[i]) pos_enc = pos_enc | COUNT_WIDTH'(i);
    end
    hit_pay = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (eq[i]) hit_pay = hit_pay | pays[i];
    end
    hit = |eq;
    full = (count == FullCount);
    do_ins = 1'b0;
    do_upd = 1'b0;
    do_rem = 1'b0;
    count_next = count;
    case (cmd_q)
      CMD_UPSERT: begin
        if (hit) begin
          do_upd = 1'b1;
          status_next = ST_UPDATED;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_ins = 1'b1;
          count_next = count + 1'b1;
          status_next = ST_INSERTED;
        end
      end
      CMD_REMOVE: begin
        if (hit) begin
          do_rem = 1'b1;
          count_next = count - 1'b1;
          status_next = ST_REMOVED;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        status_next = hit ? ST_FOUND : ST_NOT_FOUND;
      end
    endcase
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.execute) begin
        if (do_ins && !lt[i]) begin
          if (lt_prev[i]) begin
            keys[i] <= key_q;
            pays[i] <= pay_q;
          end else begin
            keys[i] <= keys[(i > 0) ? i - 1 : 0];
            pays[i] <= pays[(i > 0) ? i - 1 : 0];
          end
        end else if (do_rem && !lt[i]) begin
          if (i < TABLE_DEPTH - 1) begin
            keys[i] <= keys[(i < TABLE_DEPTH - 1) ? i + 1 : i];
            pays[i] <= pays[(i < TABLE_DEPTH - 1) ? i + 1 : i];
          end
        end else if (do_upd && eq[i]) begin
          pays[i] <= pay_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.execute) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status <= status_next;
      payload_out <= (status_next == ST_FOUND) ? hit_pay : '0;
      position <= pos_enc;
      entry_count <= count_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/sorted_key_table.sv
// The per-cell compare fills when an item is accepted; the shift/update and the
// result register are written by the execute step that follows, which a result
// still waiting delays. No new item is accepted until the current one executes.
// Reset (synchronous, active high) empties the table and clears the handshake;
// cell contents are left as they are and are never read before being written.
`default_nettype none
module sorted_key_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int PAYLOAD_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  skt_req_if.sink  req,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  localparam int CountWidth = $clog2(TABLE_DEPTH + 1);

  ctl_t ctl;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl)
  );

  skt_cells #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .COUNT_WIDTH   (CountWidth)
  ) u_cells (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .in_cmd      (req.cmd),
    .in_key      (req.key),
    .in_payload  (req.payload),
    .status      (rsp.status),
    .payload_out (rsp.payload_out),
    .position    (rsp.position),
    .entry_count (rsp.entry_count)
  );

endmodule
`default_nettype wire

>>> hw/rtl/skt_chk.sv
// Port-level checks for the sorted key table, bound to the top level.
`default_nettype none
module skt_chk #(
  parameter int TABLE_DEPTH = 64,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int COUNT_WIDTH = $clog2(TABLE_DEPTH + 1)
) (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     req_valid,
  input wire logic                     req_ready,
  input wire logic                     rsp_valid,
  input wire logic                     rsp_ready,
  input wire skt_pkg::status_t         status,
  input wire logic [PAYLOAD_WIDTH-1:0] payload_out,
  input wire logic [COUNT_WIDTH-1:0]   position,
  input wire logic [COUNT_WIDTH-1:0]   entry_count
);
  import skt_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] FullCount = COUNT_WIDTH'(TABLE_DEPTH);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken during execute");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> entry_count == FullCount)
    else $error("table full reported below depth");

  a_insert_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_INSERTED |-> position < entry_count)
    else $error("insert position outside held entries");

  a_pay_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_FOUND |-> payload_out == '0)
    else $error("payload returned without a found lookup");

endmodule

bind sorted_key_table skt_chk #(
  .TABLE_DEPTH   (TABLE_DEPTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .payload_out (rsp.payload_out),
  .position    (rsp.position),
  .entry_count (rsp.entry_count)
);
`default_nettype wire
